// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
// No dependencies; expects clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// cons must hold at every edge at which ante holds
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hw/rtl/csu_pkg.sv =====
// Cosine similarity unit: shared widths, constants and types.
// No dependencies.
package csu_pkg;

    localparam int ELEM_W  = 16;
    localparam int DOT_W   = 42;
    localparam int SQ_W    = 41;
    localparam int HALF_W  = 21;
    localparam int PROD_W  = 2 * SQ_W;
    localparam int ROOT_W  = SQ_W;
    localparam int REM_W   = ROOT_W + 2;
    localparam int QUO_W   = ELEM_W + 1;
    localparam int FRAC_W  = ELEM_W - 1;
    localparam int CNT_W   = 6;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // index of the last step of each normaliser loop
    localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(4);
    localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(PROD_W / 2 - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(QUO_W - 1);

    localparam logic signed [DOT_W-1:0] DOT_MAX = {1'b0, {(DOT_W-1){1'b1}}};
    localparam logic signed [DOT_W-1:0] DOT_MIN = {1'b1, {(DOT_W-1){1'b0}}};
    localparam logic [SQ_W-1:0]         SQ_MAX  = {SQ_W{1'b1}};

    localparam logic signed [ELEM_W-1:0] SIM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic signed [ELEM_W-1:0] SIM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};
    localparam logic [QUO_W-1:0]         QUO_POS_LIM = QUO_W'(SIM_MAX);
    localparam logic [QUO_W-1:0]         QUO_NEG_LIM = {1'b0, 1'b1, {(QUO_W-2){1'b0}}};

    // finished vector sums handed from front to back
    typedef struct packed {
        logic signed [DOT_W-1:0] dot;
        logic [SQ_W-1:0]         sum_a;
        logic [SQ_W-1:0]         sum_b;
    } csu_vec_t;

    typedef struct packed {
        logic valid;
        logic full;
    } csu_queue_stat_t;

    typedef struct packed {
        logic busy;
        logic load;
    } csu_norm_stat_t;

    typedef enum logic [5:0] {
        NS_IDLE = 6'b000001,
        NS_MUL  = 6'b000010,
        NS_ROOT = 6'b000100,
        NS_CHK  = 6'b001000,
        NS_DIV  = 6'b010000,
        NS_DONE = 6'b100000
    } csu_norm_state_t;

endpackage

// ===== hw/rtl/csu_accum.sv =====
// Front end: saturating dot product and sums of squares, one pair per beat.
// Depends on csu_pkg.
module csu_accum
    import csu_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic signed [ELEM_W-1:0] elem_a,
    input  logic signed [ELEM_W-1:0] elem_b,
    input  logic                     last,
    output logic                     push,
    output csu_vec_t                 push_data
);

    logic signed [DOT_W-1:0] dot_reg, dot_next;
    logic [SQ_W-1:0]         sa_reg, sa_next;
    logic [SQ_W-1:0]         sb_reg, sb_next;

    logic signed [2*ELEM_W-1:0] p_ab, p_aa, p_bb;
    logic signed [DOT_W:0]      dot_sum;
    logic [SQ_W:0]              sa_sum, sb_sum;
    logic signed [DOT_W-1:0]    dot_sat;
    logic [SQ_W-1:0]            sa_sat, sb_sat;

    assign p_ab = elem_a * elem_b;
    assign p_aa = elem_a * elem_a;
    assign p_bb = elem_b * elem_b;

    assign dot_sum = (DOT_W+1)'(p_ab) + {dot_reg[DOT_W-1], dot_reg};
    assign sa_sum  = {1'b0, sa_reg} + (SQ_W+1)'(p_aa[2*ELEM_W-2:0]);
    assign sb_sum  = {1'b0, sb_reg} + (SQ_W+1)'(p_bb[2*ELEM_W-2:0]);

    always_comb
    begin
        if (dot_sum[DOT_W] != dot_sum[DOT_W-1])
        begin
            dot_sat = dot_sum[DOT_W] ? DOT_MIN : DOT_MAX;
        end
        else
        begin
            dot_sat = dot_sum[DOT_W-1:0];
        end
        sa_sat = sa_sum[SQ_W] ? SQ_MAX : sa_sum[SQ_W-1:0];
        sb_sat = sb_sum[SQ_W] ? SQ_MAX : sb_sum[SQ_W-1:0];
    end

    assign push            = accept & last;
    assign push_data.dot   = dot_sat;
    assign push_data.sum_a = sa_sat;
    assign push_data.sum_b = sb_sat;

    always_comb
    begin
        dot_next = dot_reg;
        sa_next  = sa_reg;
        sb_next  = sb_reg;
        if (accept)
        begin
            // a finished vector leaves, sums restart
            dot_next = last ? '0 : dot_sat;
            sa_next  = last ? '0 : sa_sat;
            sb_next  = last ? '0 : sb_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg <= '0;
            sa_reg  <= '0;
            sb_reg  <= '0;
        end
        else
        begin
            dot_reg <= dot_next;
            sa_reg  <= sa_next;
            sb_reg  <= sb_next;
        end
    end

endmodule

// ===== hw/rtl/csu_queue.sv =====
// Short queue of finished vector sums between front and back.
// Depends on csu_pkg.
module csu_queue
    import csu_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  csu_vec_t        push_data,
    input  logic            pop,
    output csu_vec_t        pop_data,
    output csu_queue_stat_t stat
);

    csu_vec_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign stat.valid = (count_reg != '0);
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/csu_norm.sv =====
// Back end: product of the sums, integer root, division and saturation. Depends
// on csu_pkg. One step per cycle, stalled by out_stall; holds the output register.
module csu_norm
    import csu_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  csu_queue_stat_t          q_stat,
    input  csu_vec_t                 q_data,
    output logic                     pop,
    output logic signed [ELEM_W-1:0] similarity,
    output logic                     zero_magnitude,
    output logic                     out_valid,
    input  logic                     out_stall,
    output csu_norm_stat_t           stat
);

    csu_norm_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    logic signed [DOT_W-1:0]  dot_reg, dot_next;
    logic [SQ_W-1:0]          sa_reg, sa_next;
    logic [SQ_W-1:0]          sb_reg, sb_next;
    logic [2*HALF_W-1:0]      pp_reg, pp_next;
    logic [1:0]               pp_sh_reg, pp_sh_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic [ROOT_W-1:0]        root_reg, root_next;
    logic [QUO_W-1:0]         num_reg, num_next;
    logic [QUO_W-1:0]         quo_reg, quo_next;
    logic                     zero_reg, zero_next;
    logic                     ovf_reg, ovf_next;
    logic signed [ELEM_W-1:0] sim_reg, sim_next;
    logic                     zm_reg, zm_next;

    logic [HALF_W-1:0]   a_half, b_half;
    logic [2*HALF_W-1:0] pp_mul;
    logic [PROD_W-1:0]   pp_shifted;
    logic [REM_W-1:0]    rt_sh, rt_trial, dv_sh, dv_div;
    logic                rt_ge, dv_ge, ovf_chk, load;
    logic [ROOT_W-1:0]   root_eff;
    logic [DOT_W-1:0]    mag;
    logic [QUO_W-1:0]    quo_neg;
    logic signed [ELEM_W-1:0] sim_val;

    // partial products of the 41x41 product, 21-bit halves
    assign a_half = cnt_reg[0] ? {1'b0, sa_reg[SQ_W-1:HALF_W]} : sa_reg[HALF_W-1:0];
    assign b_half = cnt_reg[1] ? {1'b0, sb_reg[SQ_W-1:HALF_W]} : sb_reg[HALF_W-1:0];
    assign pp_mul = a_half * b_half;

    always_comb
    begin
        case (pp_sh_reg)
            2'd0:    pp_shifted = PROD_W'(pp_reg);
            2'd1:    pp_shifted = PROD_W'(pp_reg) << HALF_W;
            2'd2:    pp_shifted = PROD_W'(pp_reg) << (2 * HALF_W);
            default: pp_shifted = '0;
        endcase
    end

    // restoring root, two radicand bits per step
    assign rt_sh    = {rem_reg[REM_W-3:0], prod_reg[PROD_W-1:PROD_W-2]};
    assign rt_trial = {root_reg, 2'b01};
    assign rt_ge    = (rt_sh >= rt_trial);

    assign root_eff = (root_reg == '0) ? ROOT_W'(1) : root_reg;
    assign mag      = dot_reg[DOT_W-1] ? DOT_W'(-dot_reg) : DOT_W'(dot_reg);
    // quotient reaches 2^17 exactly when mag >= 4 * root
    assign ovf_chk  = ({1'b0, mag} >= {root_eff, 2'b00});

    // restoring division, one quotient bit per step
    assign dv_sh  = {rem_reg[REM_W-2:0], num_reg[QUO_W-1]};
    assign dv_div = {2'b00, root_reg};
    assign dv_ge  = (dv_sh >= dv_div);

    assign quo_neg = QUO_W'(0) - quo_reg;

    always_comb
    begin
        if (zero_reg)
        begin
            sim_val = '0;
        end
        else if (dot_reg[DOT_W-1])
        begin
            sim_val = (ovf_reg || quo_reg > QUO_NEG_LIM) ? SIM_MIN : quo_neg[ELEM_W-1:0];
        end
        else
        begin
            sim_val = (ovf_reg || quo_reg > QUO_POS_LIM) ? SIM_MAX : quo_reg[ELEM_W-1:0];
        end
    end

    assign load = (state_reg == NS_DONE) && (!out_valid_reg || !out_stall);
    assign pop  = (state_reg == NS_IDLE) && q_stat.valid;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        dot_next       = dot_reg;
        sa_next        = sa_reg;
        sb_next        = sb_reg;
        pp_next        = pp_reg;
        pp_sh_next     = pp_sh_reg;
        prod_next      = prod_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        num_next       = num_reg;
        quo_next       = quo_reg;
        zero_next      = zero_reg;
        ovf_next       = ovf_reg;
        sim_next       = sim_reg;
        zm_next        = zm_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            NS_IDLE:
            begin
                if (q_stat.valid)
                begin
                    dot_next   = q_data.dot;
                    sa_next    = q_data.sum_a;
                    sb_next    = q_data.sum_b;
                    zero_next  = (q_data.sum_a == '0) || (q_data.sum_b == '0);
                    ovf_next   = 1'b0;
                    prod_next  = '0;
                    cnt_next   = '0;
                    state_next = zero_next ? NS_DONE : NS_MUL;
                end
            end
            NS_MUL:
            begin
                // multiply into pp_reg, add the previous one into the product
                if (cnt_reg != '0)
                begin
                    prod_next = prod_reg + pp_shifted;
                end
                if (cnt_reg == MUL_LAST)
                begin
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = '0;
                    state_next = NS_ROOT;
                end
                else
                begin
                    pp_next    = pp_mul;
                    pp_sh_next = 2'(cnt_reg[0]) + 2'(cnt_reg[1]);
                    cnt_next   = cnt_reg + 1'b1;
                end
            end
            NS_ROOT:
            begin
                rem_next  = rt_ge ? rt_sh - rt_trial : rt_sh;
                root_next = {root_reg[ROOT_W-2:0], rt_ge};
                prod_next = prod_reg << 2;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == ROOT_LAST)
                begin
                    state_next = NS_CHK;
                end
            end
            NS_CHK:
            begin
                root_next  = root_eff;
                ovf_next   = ovf_chk;
                rem_next   = REM_W'(mag[DOT_W-1:2]);
                num_next   = {mag[1:0], {FRAC_W{1'b0}}};
                quo_next   = '0;
                cnt_next   = '0;
                state_next = ovf_chk ? NS_DONE : NS_DIV;
            end
            NS_DIV:
            begin
                rem_next = dv_ge ? dv_sh - dv_div : dv_sh;
                quo_next = {quo_reg[QUO_W-2:0], dv_ge};
                num_next = num_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = NS_DONE;
                end
            end
            NS_DONE:
            begin
                if (load)
                begin
                    sim_next       = sim_val;
                    zm_next        = zero_reg;
                    out_valid_next = 1'b1;
                    state_next     = NS_IDLE;
                end
            end
            default:
            begin
                state_next = NS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= NS_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dot_reg   <= dot_next;
        sa_reg    <= sa_next;
        sb_reg    <= sb_next;
        pp_reg    <= pp_next;
        pp_sh_reg <= pp_sh_next;
        prod_reg  <= prod_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        num_reg   <= num_next;
        quo_reg   <= quo_next;
        zero_reg  <= zero_next;
        ovf_reg   <= ovf_next;
        sim_reg   <= sim_next;
        zm_reg    <= zm_next;
    end

    assign similarity     = sim_reg;
    assign zero_magnitude = zm_reg;
    assign out_valid      = out_valid_reg;
    assign stat.busy      = (state_reg != NS_IDLE);
    assign stat.load      = load;

endmodule

// ===== hw/rtl/cosine_similarity_unit_top.sv =====
// Cosine similarity unit top: front accumulator, two-entry queue, back normaliser.
// Throughput: one element pair per cycle while in_stall is low. The back end takes
//   one vector at a time through product, root, range check, divide and hand-over,
//   skips the divide when the quotient overflows and goes straight to hand-over when
//   a sum is zero. in_stall rises only while two finished vectors wait.
// Reset (rst_n, async low) clears sums, queue, sequencer and output valid.
`include "assert_macros.svh"

module cosine_similarity_unit_top
    import csu_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [ELEM_W-1:0] elem_a,
    input  logic signed [ELEM_W-1:0] elem_b,
    input  logic                     last,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [ELEM_W-1:0] similarity,
    output logic                     zero_magnitude
);

    logic            in_accept;
    logic            q_push;
    logic            q_pop;
    csu_vec_t        q_wdata;
    csu_vec_t        q_rdata;
    csu_queue_stat_t q_stat;
    csu_norm_stat_t  n_stat;

    // Stall only while the queue is full: the front end keeps summing while
    // the back end normalises earlier vectors.
    assign in_stall  = q_stat.full;
    assign in_accept = in_valid && !in_stall;

    // Front: saturating sums; a last beat hands the finished sums on.
    csu_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .elem_a    (elem_a),
        .elem_b    (elem_b),
        .last      (last),
        .push      (q_push),
        .push_data (q_wdata)
    );

    // Decouples the one-beat front from the multi-cycle back.
    csu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .stat      (q_stat)
    );

    // Back: product of sums, root, divide, saturate, output register.
    csu_norm u_norm (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_stat         (q_stat),
        .q_data         (q_rdata),
        .pop            (q_pop),
        .similarity     (similarity),
        .zero_magnitude (zero_magnitude),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .stat           (n_stat)
    );

    // Queue must never be written while full.
    `ASSERT_IMPLY(a_no_push_full, q_push, !q_stat.full, "queue written while full")
    // A zero-magnitude result carries a zero similarity.
    `ASSERT_IMPLY(a_zero_result, out_valid && zero_magnitude, similarity == '0, "bad zero result")
    // New result only goes into a free or draining output register.
    `ASSERT_IMPLY(a_load_free, n_stat.load, !out_valid || !out_stall, "held beat overwritten")
    // The back end only pops while idle.
    `ASSERT_IMPLY(a_pop_idle, q_pop, !n_stat.busy && q_stat.valid, "pop while busy or empty")

endmodule
